/* src/fic_pkg.sv */
package fic_pkg;

   localparam int MAX_PLANES = 6;
   localparam int PLANE_AW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   localparam int NORM_W     = 18;
   localparam int COORD_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int COUNT_W    = 3;
   localparam int MARGIN_W   = 31;

   localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
   localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_POS_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_POS_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_POS_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_MARGIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM_MARGIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_RANGE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_OK     = 3'd7;

   localparam logic [MARGIN_W-1:0] HOT_MARGIN_RST  = 31'd16384;
   localparam logic [MARGIN_W-1:0] WARM_MARGIN_RST = 31'd65536;
   localparam logic [MARGIN_W-1:0] NEAR_RANGE_RST  = 31'd32768;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [1:0] INTEREST_HOT     = 2'd0;
   localparam logic [1:0] INTEREST_WARM    = 2'd1;
   localparam logic [1:0] INTEREST_DORMANT = 2'd2;

   typedef struct packed {
      logic                      operation;
      logic [2:0]                plane_slot;
      logic signed [COORD_W-1:0] lower_x;
      logic signed [COORD_W-1:0] lower_y;
      logic signed [COORD_W-1:0] lower_z;
      logic signed [COORD_W-1:0] upper_x;
      logic signed [COORD_W-1:0] upper_y;
      logic signed [COORD_W-1:0] upper_z;
      logic                      bounds_finite;
      logic                      recently_hot;
   } req_type;

   typedef struct packed {
      logic [1:0] interest;
      logic       stamp_hot;
   } rsp_type;

   typedef struct packed {
      logic signed [NORM_W-1:0]  nx;
      logic signed [NORM_W-1:0]  ny;
      logic signed [NORM_W-1:0]  nz;
      logic signed [COORD_W-1:0] offset;
   } plane_type;

   localparam int PLANE_W = $bits(plane_type);

   function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [COORD_W-1:0] v);
      logic signed [NORM_W-1:0] r;
      if (v > COORD_W'(NORM_MAX)) begin
         r = NORM_MAX;
      end else if (v < COORD_W'(NORM_MIN)) begin
         r = NORM_MIN;
      end else begin
         r = v[NORM_W-1:0];
      end
      return r;
   endfunction

endpackage

/* src/fic_ram.sv */
module fic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/frustum_interest_classifier.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    fic_pkg::req_type (load plane or classify box)
// rsp_      out        rsp_valid/rsp_ready    fic_pkg::rsp_type (one per classify transaction)
// csr_      in         csr_valid/csr_ready    csr_index, csr_data (csr_ready always high)
//
// A load transaction writes the plane store in its accept cycle; the next one is taken at once.
// A classify transaction runs one plane per cycle through the plane store read port and the
// multiply stage, then waits in the drain state until the pipeline is empty and registers the
// result from the report state (it goes straight to drain when the view is unusable).
// One item is in flight at a time; req_ready is high only while the sequencer is idle.
// A stalled result sits in the output register; the sequencer waits for it to drain.
// Synchronous reset restores the CSR defaults and clears the plane valid bits, pipeline flags and control state.
module frustum_interest_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fic_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fic_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fic_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLANES,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   state_type state_ff;

   // configuration
   logic signed [31:0]                   view_pos_x_ff, view_pos_y_ff, view_pos_z_ff;
   logic [fic_pkg::COUNT_W-1:0]          active_ff;
   logic [fic_pkg::MARGIN_W-1:0]         hot_margin_ff, warm_margin_ff, near_range_ff;
   logic                                 view_ok_ff;

   logic                                 csr_fire;
   logic                                 req_fire;
   logic                                 load_fire;
   logic                                 slot_ok;
   logic                                 usable;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign slot_ok   = {1'b0, req_data.plane_slot} < 4'(fic_pkg::MAX_PLANES);
   assign load_fire = req_fire & (req_data.operation == fic_pkg::OP_LOAD) & slot_ok;
   assign usable    = view_ok_ff & (active_ff != '0) &
                      ({1'b0, active_ff} <= 4'(fic_pkg::MAX_PLANES));

   always_ff @(posedge clock) begin
      if (reset) begin
         view_pos_x_ff  <= '0;
         view_pos_y_ff  <= '0;
         view_pos_z_ff  <= '0;
         active_ff      <= '0;
         hot_margin_ff  <= fic_pkg::HOT_MARGIN_RST;
         warm_margin_ff <= fic_pkg::WARM_MARGIN_RST;
         near_range_ff  <= fic_pkg::NEAR_RANGE_RST;
         view_ok_ff     <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index)
            fic_pkg::CSR_VIEW_POS_X:  view_pos_x_ff  <= csr_data;
            fic_pkg::CSR_VIEW_POS_Y:  view_pos_y_ff  <= csr_data;
            fic_pkg::CSR_VIEW_POS_Z:  view_pos_z_ff  <= csr_data;
            fic_pkg::CSR_ACTIVE:      active_ff      <= csr_data[fic_pkg::COUNT_W-1:0];
            fic_pkg::CSR_HOT_MARGIN:  hot_margin_ff  <= csr_data[fic_pkg::MARGIN_W-1:0];
            fic_pkg::CSR_WARM_MARGIN: warm_margin_ff <= csr_data[fic_pkg::MARGIN_W-1:0];
            fic_pkg::CSR_NEAR_RANGE:  near_range_ff  <= csr_data[fic_pkg::MARGIN_W-1:0];
            fic_pkg::CSR_VIEW_OK:     view_ok_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // plane store
   fic_pkg::plane_type                   wr_plane;
   logic [fic_pkg::PLANE_W-1:0]          rd_word;
   logic [fic_pkg::PLANE_AW-1:0]         wr_addr;
   logic [fic_pkg::PLANE_AW-1:0]         rd_addr;
   logic [fic_pkg::COUNT_W-1:0]          plane_ff;
   logic [fic_pkg::MAX_PLANES-1:0]       entry_valid_ff;
   logic                                 issue;
   logic                                 rd_ok_ff;

   assign wr_plane.nx     = fic_pkg::sat_norm(req_data.lower_x);
   assign wr_plane.ny     = fic_pkg::sat_norm(req_data.lower_y);
   assign wr_plane.nz     = fic_pkg::sat_norm(req_data.lower_z);
   assign wr_plane.offset = req_data.upper_x;
   assign wr_addr         = req_data.plane_slot[fic_pkg::PLANE_AW-1:0];
   assign rd_addr         = plane_ff[fic_pkg::PLANE_AW-1:0];
   assign issue           = (state_ff == ST_PLANES);

   fic_ram #(
      .WIDTH (fic_pkg::PLANE_W),
      .DEPTH (fic_pkg::MAX_PLANES)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (wr_addr),
      .wr_data (wr_plane),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (load_fire) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // box and pipeline flags
   fic_pkg::req_type                     box_ff;
   logic                                 start_ff, sq_v_ff, rdv_ff, prod_v_ff;
   logic                                 pipe_busy;

   assign pipe_busy = start_ff | sq_v_ff | rdv_ff | prod_v_ff;

   // plane test: one plane per cycle, multiply stage then sum and compare
   fic_pkg::plane_type                   rd_plane;
   logic signed [49:0]                   prod_in [3];
   logic signed [49:0]                   prod_ff [3];
   logic signed [31:0]                   offset_ff;
   logic signed [52:0]                   acc;
   logic signed [52:0]                   hot_limit, warm_limit;
   logic                                 hot_all_ff, warm_all_ff;

   assign rd_plane = rd_ok_ff ? fic_pkg::plane_type'(rd_word) : '0;

   always_comb begin
      prod_in[0] = 50'(rd_plane.nx) *
                   50'((rd_plane.nx >= 0) ? box_ff.upper_x : box_ff.lower_x);
      prod_in[1] = 50'(rd_plane.ny) *
                   50'((rd_plane.ny >= 0) ? box_ff.upper_y : box_ff.lower_y);
      prod_in[2] = 50'(rd_plane.nz) *
                   50'((rd_plane.nz >= 0) ? box_ff.upper_z : box_ff.lower_z);
   end

   assign acc = $signed({{5{offset_ff[31]}}, offset_ff, 16'b0})
              + 53'(prod_ff[0]) + 53'(prod_ff[1]) + 53'(prod_ff[2]);
   assign hot_limit  = -$signed({6'b0, hot_margin_ff, 16'b0});
   assign warm_limit = -$signed({6'b0, warm_margin_ff, 16'b0});

   // near test: clamp, square, sum
   logic signed [31:0]                   pos [3];
   logic signed [31:0]                   lo  [3];
   logic signed [31:0]                   hi  [3];
   logic signed [31:0]                   clamp [3];
   logic signed [32:0]                   delta [3];
   logic signed [65:0]                   sq_full [3];
   logic [63:0]                          sq_ff [3];
   logic [61:0]                          nr2_ff;
   logic [65:0]                          sq_sum;
   logic                                 near_ff;

   always_comb begin
      pos[0] = view_pos_x_ff;
      pos[1] = view_pos_y_ff;
      pos[2] = view_pos_z_ff;
      lo[0]  = box_ff.lower_x;
      lo[1]  = box_ff.lower_y;
      lo[2]  = box_ff.lower_z;
      hi[0]  = box_ff.upper_x;
      hi[1]  = box_ff.upper_y;
      hi[2]  = box_ff.upper_z;
      for (int a = 0; a < 3; a++) begin
         if (pos[a] < lo[a]) begin
            clamp[a] = lo[a];
         end else if (hi[a] < pos[a]) begin
            clamp[a] = hi[a];
         end else begin
            clamp[a] = pos[a];
         end
         delta[a]   = 33'(pos[a]) - 33'(clamp[a]);
         sq_full[a] = 66'(delta[a]) * 66'(delta[a]);
      end
   end

   // unsaturated sum: near_range^2 < 2^62, so saturating at 2^64-1 cannot change the compare
   assign sq_sum = {2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 1'b0;
         sq_v_ff   <= 1'b0;
         rdv_ff    <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         start_ff  <= req_fire & (req_data.operation == fic_pkg::OP_CLASSIFY);
         sq_v_ff   <= start_ff;
         rdv_ff    <= issue;
         prod_v_ff <= rdv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff      <= req_data;
         hot_all_ff  <= 1'b1;
         warm_all_ff <= 1'b1;
      end else if (prod_v_ff) begin
         hot_all_ff  <= hot_all_ff & (acc >= hot_limit);
         warm_all_ff <= warm_all_ff & (acc >= warm_limit);
      end
      if (issue) begin
         rd_ok_ff <= entry_valid_ff[rd_addr];
      end
      if (rdv_ff) begin
         for (int a = 0; a < 3; a++) begin
            prod_ff[a] <= prod_in[a];
         end
         offset_ff <= rd_plane.offset;
      end
      if (start_ff) begin
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= sq_full[a][63:0];
         end
         nr2_ff <= 62'(near_range_ff) * 62'(near_range_ff);
      end
      if (sq_v_ff) begin
         near_ff <= (sq_sum <= {4'b0, nr2_ff});
      end
   end

   // result
   logic                                 hot_hit;
   logic [1:0]                           interest_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_load;
   fic_pkg::rsp_type                     rsp_data_ff;

   assign hot_hit  = ~usable | ~box_ff.bounds_finite | near_ff | hot_all_ff;
   assign rsp_load = (state_ff == ST_REPORT) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      if (hot_hit) begin
         interest_in = fic_pkg::INTEREST_HOT;
      end else if (warm_all_ff | box_ff.recently_hot) begin
         interest_in = fic_pkg::INTEREST_WARM;
      end else begin
         interest_in = fic_pkg::INTEREST_DORMANT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_data.operation == fic_pkg::OP_CLASSIFY) begin
                  plane_ff <= '0;
                  state_ff <= usable ? ST_PLANES : ST_DRAIN;
               end
            end
            ST_PLANES: begin
               if (plane_ff == active_ff - 3'd1) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  plane_ff <= plane_ff + 3'd1;
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  state_ff <= ST_REPORT;
               end
            end
            ST_REPORT: begin
               if (rsp_load) begin
                  rsp_data_ff.interest  <= interest_in;
                  rsp_data_ff.stamp_hot <= (interest_in == fic_pkg::INTEREST_HOT);
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* test/fic_checker.sv */
module fic_checker
   import fic_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output int                   mismatches,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [64:0] SQ_CEIL = {1'b0, {64{1'b1}}};

   logic signed [COORD_W-1:0] view_pos [3];
   logic [COUNT_W-1:0]        plane_count;
   logic [MARGIN_W-1:0]       hot_pad;
   logic [MARGIN_W-1:0]       warm_pad;
   logic [MARGIN_W-1:0]       near_dist;
   logic                      view_valid;
   logic signed [NORM_W-1:0]  normal_mem [MAX_PLANES][3];
   logic signed [COORD_W-1:0] offset_mem [MAX_PLANES];

   rsp_type interest_q [$];
   int      failures = 0;
   int      reported = 0;
   int      waiting  = 0;

   assign mismatches = failures;
   assign pending    = waiting;

   function automatic logic signed [NORM_W-1:0] clip_normal(logic signed [COORD_W-1:0] v);
      if (longint'(v) > longint'(NORM_MAX)) return NORM_MAX;
      if (longint'(v) < longint'(NORM_MIN)) return NORM_MIN;
      return v[NORM_W-1:0];
   endfunction

   function automatic longint box_edge(req_type b, int a, logic upper);
      logic signed [COORD_W-1:0] v;
      case (a)
         0:       v = upper ? b.upper_x : b.lower_x;
         1:       v = upper ? b.upper_y : b.lower_y;
         default: v = upper ? b.upper_z : b.lower_z;
      endcase
      return longint'(v);
   endfunction

   function automatic logic passes_planes(req_type b, logic [MARGIN_W-1:0] pad);
      longint acc;
      longint floor_v;
      longint n;
      floor_v = -(longint'(pad) * 65536);
      for (int p = 0; p < MAX_PLANES && p < plane_count; p++) begin
         acc = longint'(offset_mem[p]) * 65536;
         for (int a = 0; a < 3; a++) begin
            n = longint'(normal_mem[p][a]);
            acc += n * box_edge(b, a, n >= 0);
         end
         if (acc < floor_v) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic near_viewer(req_type b);
      longint      c;
      longint      d;
      logic [64:0] mag;
      logic [64:0] total;
      total = '0;
      for (int a = 0; a < 3; a++) begin
         c = longint'(view_pos[a]);
         if (c < box_edge(b, a, 1'b0)) begin
            c = box_edge(b, a, 1'b0);
         end else if (box_edge(b, a, 1'b1) < c) begin
            c = box_edge(b, a, 1'b1);
         end
         d = longint'(view_pos[a]) - c;
         mag = 65'((d < 0) ? -d : d);
         total = total + mag * mag;
         if (total > SQ_CEIL) total = SQ_CEIL;
      end
      return total <= {34'd0, near_dist} * {34'd0, near_dist};
   endfunction

   function automatic rsp_type classify_box(req_type b);
      rsp_type r;
      logic    usable;
      usable = view_valid && plane_count != 0 && plane_count <= MAX_PLANES;
      if (!usable || !b.bounds_finite || near_viewer(b) || passes_planes(b, hot_pad)) begin
         r.interest = INTEREST_HOT;
      end else if (passes_planes(b, warm_pad) || b.recently_hot) begin
         r.interest = INTEREST_WARM;
      end else begin
         r.interest = INTEREST_DORMANT;
      end
      r.stamp_hot = (r.interest == INTEREST_HOT);
      return r;
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (reported < 10) begin
         reported++;
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         view_pos[0] = '0;
         view_pos[1] = '0;
         view_pos[2] = '0;
         plane_count = '0;
         hot_pad     = HOT_MARGIN_RST;
         warm_pad    = WARM_MARGIN_RST;
         near_dist   = NEAR_RANGE_RST;
         view_valid  = 1'b0;
         for (int p = 0; p < MAX_PLANES; p++) begin
            for (int a = 0; a < 3; a++) normal_mem[p][a] = '0;
            offset_mem[p] = '0;
         end
         interest_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (interest_q.size() == 0) begin
               note_failure($sformatf("unexpected transaction: interest %0d stamp_hot %0d",
                                      rsp_data.interest, rsp_data.stamp_hot));
            end else begin
               want = interest_q.pop_front();
               if (rsp_data.interest !== want.interest) begin
                  note_failure($sformatf("interest: expected %0d, got %0d",
                                         want.interest, rsp_data.interest));
               end
               if (rsp_data.stamp_hot !== want.stamp_hot) begin
                  note_failure($sformatf("stamp_hot: expected %0d, got %0d",
                                         want.stamp_hot, rsp_data.stamp_hot));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VIEW_POS_X:  view_pos[0] = csr_data;
               CSR_VIEW_POS_Y:  view_pos[1] = csr_data;
               CSR_VIEW_POS_Z:  view_pos[2] = csr_data;
               CSR_ACTIVE:      plane_count = csr_data[COUNT_W-1:0];
               CSR_HOT_MARGIN:  hot_pad     = csr_data[MARGIN_W-1:0];
               CSR_WARM_MARGIN: warm_pad    = csr_data[MARGIN_W-1:0];
               CSR_NEAR_RANGE:  near_dist   = csr_data[MARGIN_W-1:0];
               CSR_VIEW_OK:     view_valid  = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.operation == OP_LOAD) begin
               if (req_data.plane_slot < MAX_PLANES) begin
                  normal_mem[req_data.plane_slot][0] = clip_normal(req_data.lower_x);
                  normal_mem[req_data.plane_slot][1] = clip_normal(req_data.lower_y);
                  normal_mem[req_data.plane_slot][2] = clip_normal(req_data.lower_z);
                  offset_mem[req_data.plane_slot]    = req_data.upper_x;
               end
            end else begin
               interest_q.insert(interest_q.size(), classify_box(req_data));
            end
         end
      end
      waiting = interest_q.size();
   end

endmodule

/* test/tb_frustum_interest_classifier.sv */
module tb_frustum_interest_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import fic_pkg::*;

   localparam int          RANDOM_ITEMS   = 1200;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [31:0] CMAX           = 32'h7FFF_FFFF;
   localparam logic [31:0] CMIN           = 32'h8000_0000;
   localparam logic [30:0] PAD_MAX        = 31'h7FFF_FFFF;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;
   int                   mismatches;
   int                   pending;
   bit                   steady;

   frustum_interest_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fic_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] near_coord();
      return $urandom_range(0, 131072) - 65536;
   endfunction

   function automatic req_type plane_item(logic [2:0] slot, logic [31:0] nx, logic [31:0] ny,
                                          logic [31:0] nz, logic [31:0] offset);
      req_type t;
      t.operation     = OP_LOAD;
      t.plane_slot    = slot;
      t.lower_x       = nx;
      t.lower_y       = ny;
      t.lower_z       = nz;
      t.upper_x       = offset;
      t.upper_y       = $urandom;
      t.upper_z       = $urandom;
      t.bounds_finite = 1'($urandom_range(0, 1));
      t.recently_hot  = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic req_type box_item(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                        logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                                        logic finite, logic recent);
      req_type t;
      t.operation     = OP_CLASSIFY;
      t.plane_slot    = 3'($urandom_range(0, 7));
      t.lower_x       = lx;
      t.lower_y       = ly;
      t.lower_z       = lz;
      t.upper_x       = ux;
      t.upper_y       = uy;
      t.upper_z       = uz;
      t.bounds_finite = finite;
      t.recently_hot  = recent;
      return t;
   endfunction

   function automatic req_type make_load(logic [2:0] slot, bit wide);
      return plane_item(slot, wide ? $urandom : near_coord(), wide ? $urandom : near_coord(),
                        wide ? $urandom : near_coord(), wide ? $urandom : near_coord());
   endfunction

   function automatic req_type make_box(bit wide);
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
      for (int k = 0; k < 3; k++) begin
         a = wide ? $urandom : near_coord();
         b = wide ? $urandom : near_coord();
         if (a > b && $urandom_range(0, 19) != 0) begin
            lo[k] = b;
            hi[k] = a;
         end else begin
            lo[k] = a;
            hi[k] = b;
         end
      end
      return box_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                      $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_item(req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_view(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [2:0] planes, logic [30:0] hot, logic [30:0] warm,
                               logic [30:0] near, logic ok);
      logic [31:0] junk;
      write_reg(CSR_VIEW_POS_X, px);
      write_reg(CSR_VIEW_POS_Y, py);
      write_reg(CSR_VIEW_POS_Z, pz);
      junk = $urandom;
      write_reg(CSR_ACTIVE, {junk[31:3], planes});
      junk = $urandom;
      write_reg(CSR_HOT_MARGIN, {junk[31], hot});
      junk = $urandom;
      write_reg(CSR_WARM_MARGIN, {junk[31], warm});
      junk = $urandom;
      write_reg(CSR_NEAR_RANGE, {junk[31], near});
      junk = $urandom;
      write_reg(CSR_VIEW_OK, {junk[31:1], ok});
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int          sent;
      int          boxes;
      bit          wide;
      logic [2:0]  planes;
      logic [30:0] hot;
      logic [30:0] warm;
      logic [30:0] near;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      steady    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset view is unusable
      send_item(box_item(0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
      send_item(plane_item(0, 65536, 0, 0, 0));
      send_item(plane_item(1, CMAX, CMIN, 0, CMAX));
      send_item(plane_item(2, 0, 0, -65536, CMIN));
      send_item(plane_item(6, 65536, 65536, 65536, CMIN));
      send_item(plane_item(7, CMIN, CMIN, CMIN, CMIN));
      send_item(plane_item(3, 0, -65536, 0, 4096));
      settle();

      program_view(CMIN, CMAX, 0, 3'd2, 31'd0, PAD_MAX, 31'd0, 1'b1);
      send_item(box_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1, 1'b0));
      send_item(box_item(256000, 0, 0, 512000, 1000, 1000, 1'b1, 1'b0));
      send_item(box_item(256000, 0, 0, 512000, 1000, 1000, 1'b0, 1'b0));
      send_item(box_item(1000, 1000, 1000, -1000, -1000, -1000, 1'b1, 1'b0));
      send_item(box_item(-512000, 0, 0, -256000, 1000, 1000, 1'b1, 1'b1));
      settle();

      program_view(0, 0, 0, 3'd4, 31'd0, 31'd0, 31'd0, 1'b1);
      send_item(box_item(256, 256, 256, 512, 512, 512, 1'b1, 1'b0));
      send_item(box_item(256, 256, 256, 512, 512, 512, 1'b1, 1'b1));
      settle();

      program_view(0, 0, 0, 3'd7, 31'd0, 31'd0, 31'd0, 1'b1);
      send_item(box_item(256, 256, 256, 512, 512, 512, 1'b1, 1'b0));
      settle();

      program_view(0, 0, 0, 3'd2, 31'd0, 31'd0, 31'd0, 1'b0);
      send_item(box_item(256, 256, 256, 512, 512, 512, 1'b1, 1'b0));
      settle();

      // warm padding below hot padding, saturating distance sum
      program_view(CMIN, CMIN, CMIN, 3'd1, PAD_MAX, 31'd0, PAD_MAX, 1'b1);
      send_item(box_item(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 1'b1, 1'b0));
      send_item(box_item(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 1'b1, 1'b1));
      send_item(box_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1, 1'b0));
      settle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wide   = ($urandom_range(0, 3) == 0);
         steady = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 19))
            0:       planes = 3'd0;
            1:       planes = 3'd7;
            default: planes = 3'($urandom_range(1, MAX_PLANES));
         endcase
         case ($urandom_range(0, 19))
            0, 1:    hot = 31'd0;
            2:       hot = PAD_MAX;
            default: hot = 31'($urandom_range(0, 1 << 17));
         endcase
         case ($urandom_range(0, 19))
            0, 1:    warm = 31'($urandom_range(0, hot));
            2:       warm = PAD_MAX;
            default: warm = 31'(hot + $urandom_range(0, 1 << 17));
         endcase
         case ($urandom_range(0, 19))
            0, 1:    near = 31'd0;
            2:       near = PAD_MAX;
            default: near = 31'($urandom_range(0, 1 << 16));
         endcase
         program_view(wide ? $urandom : near_coord(), wide ? $urandom : near_coord(),
                      wide ? $urandom : near_coord(), planes, hot, warm, near,
                      $urandom_range(0, 15) != 0);
         for (int s = 0; s < MAX_PLANES; s++) begin
            send_item(make_load(3'(s), wide));
            sent++;
         end
         boxes = $urandom_range(40, 100);
         repeat (boxes) begin
            if ($urandom_range(0, 24) == 0)
               send_item(make_load(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
            else
               send_item(make_box(wide));
            sent++;
         end
         settle();
      end

      if (mismatches == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
